// File: rtl/lgl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lgl_pkg
// Shared types and constants of the toroidal life grid engine: item and
// result beats, row cell control, sequencer states and rule counts.
// ----------------------------------------------------------------------------
package lgl_pkg;

	localparam logic [2:0] MODE_TOGGLE = 3'd0;
	localparam logic [2:0] MODE_CLEAR  = 3'd1;
	localparam logic [2:0] MODE_FLIP   = 3'd2;
	localparam logic [2:0] MODE_TICK   = 3'd3;
	localparam logic [2:0] MODE_READ   = 3'd4;

	localparam logic [3:0] BORN_COUNT = 4'd3;
	localparam logic [3:0] STAY_LOW   = 4'd2;
	localparam logic [3:0] STAY_HIGH  = 4'd3;
	localparam logic [3:0] DIV_RESET  = 4'd5;
	localparam logic [3:0] DIV_MAX    = 4'd8;

	localparam int ROW_FIELD_W = 40;

	typedef struct packed {
		logic [2:0] mode;
		logic [4:0] cell_row;
		logic [5:0] cell_col;
	} lgl_item_t;

	typedef struct packed {
		logic [ROW_FIELD_W-1:0] row_bits;
		logic                   running;
		logic                   generation_done;
	} lgl_result_t;

	typedef struct packed {
		logic shift;
		logic clear;
		logic toggle;
	} lgl_cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GEN,
		ST_RPT
	} lgl_state_t;

endpackage
`default_nettype wire

// File: rtl/lgl_row_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lgl_row_cell
// One grid row of the row chain. Takes its neighbor's row on a shift, and
// otherwise clears or toggles bits in place.
// ----------------------------------------------------------------------------
module lgl_row_cell
	import lgl_pkg::*;
#(
	parameter int COLS = 40
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lgl_cell_ctl_t ctl,
	input  wire logic [COLS-1:0] shift_in,
	input  wire logic [COLS-1:0] toggle_mask,
	output logic [COLS-1:0]    row
);

	logic [COLS-1:0] row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctl.shift) begin
			row_q <= shift_in;
		end else if (ctl.clear) begin
			row_q <= '0;
		end else if (ctl.toggle) begin
			row_q <= row_q ^ toggle_mask;
		end
	end

	assign row = row_q;

endmodule
`default_nettype wire

// File: rtl/lgl_row_rule.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lgl_row_rule
// Next-generation row from a three-row window, B3/S23 with columns that
// wrap around.
// ----------------------------------------------------------------------------
module lgl_row_rule
	import lgl_pkg::*;
#(
	parameter int COLS = 40
) (
	input  wire logic [COLS-1:0] up,
	input  wire logic [COLS-1:0] mid,
	input  wire logic [COLS-1:0] dn,
	output logic [COLS-1:0]      nxt
);

	always_comb begin
		for (int j = 0; j < COLS; j++) begin
			int lf;
			int rt;
			logic [3:0] n;
			lf = (j == 0) ? COLS - 1 : j - 1;
			rt = (j == COLS - 1) ? 0 : j + 1;
			n = {3'b0, up[lf]} + {3'b0, up[j]} + {3'b0, up[rt]}
			  + {3'b0, mid[lf]} + {3'b0, mid[rt]}
			  + {3'b0, dn[lf]} + {3'b0, dn[j]} + {3'b0, dn[rt]};
			if (mid[j]) begin
				nxt[j] = (n >= STAY_LOW) && (n <= STAY_HIGH);
			end else begin
				nxt[j] = (n == BORN_COUNT);
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/toroidal_life_grid_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// toroidal_life_grid_engine
// Wrap-around B3/S23 life grid held in a chain of row cells.
// ----------------------------------------------------------------------------
// An accepted item is held in one input slot and executed from there. A
// toggle, clear, flip, read or non-generating tick goes straight to the
// report step; a tick that computes a generation first runs the
// generation pass, the row chain rotating one row per cycle through
// the rule unit. The next item is taken the cycle after a result leaves
// the slot; no item is taken before the last has reported. A finished
// result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module toroidal_life_grid_engine
	import lgl_pkg::*;
#(
	parameter int GRID_ROWS = 30,
	parameter int GRID_COLS = 40
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire lgl_item_t   item,
	output logic             result_valid,
	input  wire logic        result_stall,
	output lgl_result_t      result,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_data
);

	localparam int RW = $clog2(GRID_ROWS);
	localparam logic [6:0] ROWS_L = 7'(GRID_ROWS);
	localparam logic [6:0] COLS_L = 7'(GRID_COLS);
	localparam logic [RW-1:0] LAST_ROW = RW'(GRID_ROWS - 1);

	lgl_state_t state_q, state_d;

	lgl_item_t   pend_q;
	logic        pend_valid_q;
	logic        run_q;
	logic [2:0]  fc_q;
	logic [3:0]  fpg_q;
	logic        done_q;
	logic [RW-1:0] t_q;
	logic [GRID_COLS-1:0] prev_q;
	logic [GRID_COLS-1:0] first_q;
	lgl_result_t out_q;
	logic        out_valid_q;

	logic [GRID_COLS-1:0] rows_w [GRID_ROWS];
	logic [GRID_COLS-1:0] nxt_row;
	logic [GRID_COLS-1:0] up_row;
	logic [GRID_COLS-1:0] dn_row;
	logic [GRID_COLS-1:0] toggle_mask;
	logic [RW-1:0]        row_idx;
	logic                 row_ok;
	logic                 col_ok;
	logic                 out_free;
	logic                 exec;
	logic                 start_gen;
	logic                 do_toggle;
	logic                 do_clear;
	logic                 do_flip;
	logic                 do_tick;
	logic                 shift;
	logic                 report;
	logic [3:0]           div;
	logic [3:0]           fc_inc;
	logic [2:0]           fc_nxt;

	assign cfg_ready  = 1'b1;
	assign item_stall = pend_valid_q;
	assign out_free   = !out_valid_q || !result_stall;

	assign row_ok  = {2'b0, pend_q.cell_row} < ROWS_L;
	assign col_ok  = {1'b0, pend_q.cell_col} < COLS_L;
	assign row_idx = RW'(pend_q.cell_row);
	assign toggle_mask = {{(GRID_COLS-1){1'b0}}, 1'b1} << pend_q.cell_col;

	assign div = (fpg_q == 4'd0) ? 4'd1 : ((fpg_q > DIV_MAX) ? DIV_MAX : fpg_q);
	assign fc_inc = {1'b0, fc_q} + 4'd1;
	assign fc_nxt = (fc_inc >= div) ? 3'd0 : fc_inc[2:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pend_valid_q) begin
					state_d = start_gen ? ST_GEN : ST_RPT;
				end
			end
			ST_GEN: begin
				if (t_q == LAST_ROW) begin
					state_d = ST_RPT;
				end
			end
			ST_RPT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		exec      = (state_q == ST_IDLE) && pend_valid_q;
		start_gen = exec && (pend_q.mode == MODE_TICK) && run_q && (fc_q == 3'd0);
		do_toggle = exec && !run_q && (pend_q.mode == MODE_TOGGLE) && row_ok && col_ok;
		do_clear  = exec && !run_q && (pend_q.mode == MODE_CLEAR);
		do_flip   = exec && (pend_q.mode == MODE_FLIP);
		do_tick   = exec && (pend_q.mode == MODE_TICK) && run_q;
		shift     = (state_q == ST_GEN);
		report    = (state_q == ST_RPT) && out_free;
	end

	assign up_row = (t_q == '0) ? rows_w[GRID_ROWS-1] : prev_q;
	assign dn_row = (t_q == LAST_ROW) ? first_q : rows_w[1];

	lgl_row_rule #(
		.COLS(GRID_COLS)
	) u_rule (
		.up (up_row),
		.mid(rows_w[0]),
		.dn (dn_row),
		.nxt(nxt_row)
	);

	for (genvar k = 0; k < GRID_ROWS; k++) begin : g_cell
		lgl_cell_ctl_t        ctl;
		logic [GRID_COLS-1:0] shift_in;

		assign ctl.shift  = shift;
		assign ctl.clear  = do_clear;
		assign ctl.toggle = do_toggle && (row_idx == RW'(k));

		if (k == GRID_ROWS - 1) begin : g_tail
			assign shift_in = nxt_row;
		end else begin : g_link
			assign shift_in = rows_w[k+1];
		end

		lgl_row_cell #(
			.COLS(GRID_COLS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.shift_in   (shift_in),
			.toggle_mask(toggle_mask),
			.row        (rows_w[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_valid_q <= 1'b0;
			run_q        <= 1'b0;
			fc_q         <= 3'd0;
			fpg_q        <= DIV_RESET;
			done_q       <= 1'b0;
			t_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				fpg_q <= cfg_data;
			end
			if (item_valid && !item_stall) begin
				pend_valid_q <= 1'b1;
			end else if (report) begin
				pend_valid_q <= 1'b0;
			end
			if (do_flip) begin
				run_q <= !run_q;
			end
			if (do_tick) begin
				fc_q <= fc_nxt;
			end
			if (exec) begin
				done_q <= start_gen;
				t_q    <= '0;
			end else if (shift) begin
				t_q <= t_q + RW'(1);
			end
			if (report) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			pend_q <= item;
		end
		if (shift) begin
			prev_q <= rows_w[0];
			if (t_q == '0) begin
				first_q <= rows_w[0];
			end
		end
		if (report) begin
			out_q.row_bits        <= row_ok ? ROW_FIELD_W'(rows_w[row_idx]) : '0;
			out_q.running         <= run_q;
			out_q.generation_done <= done_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_idle_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!pend_valid_q |-> state_q == ST_IDLE)
		else $error("sequencer busy without a pending item");

	a_gen_is_tick: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GEN |-> pend_valid_q && pend_q.mode == MODE_TICK && run_q)
		else $error("generation pass without a running tick");

	a_done_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.generation_done |-> out_q.running)
		else $error("generation reported while paused");

	a_result_from_report: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RPT))
		else $error("result beat without a report step");

endmodule
`default_nettype wire
